// ===== hw/rtl/rvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rankine vortex seed package
// Shared types, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package rvs_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Square root: the radicand is padded to an even width, one bit pair per stage.
  localparam int unsigned SQ_RAD_W  = 66;
  localparam int unsigned SQ_ROOT_W = 33;

  // Divider: the quotient fits in DIV_Q_W bits when the numerator's upper half is below the divisor.
  localparam int unsigned DIV_NUM_W = 64;
  localparam int unsigned DIV_DEN_W = 33;
  localparam int unsigned DIV_Q_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_CORE_RADIUS = 3'd3,
    REG_PEAK_SPEED  = 3'd4,
    REG_SEED_TOP    = 3'd5
  } rvs_reg_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] height;
    logic signed [31:0] wind_u_in;
    logic signed [31:0] wind_v_in;
  } rvs_in_t;

  typedef struct packed {
    logic signed [31:0] wind_u_out;
    logic signed [31:0] wind_v_out;
  } rvs_out_t;

  // Per-cell context carried alongside the arithmetic units.
  typedef struct packed {
    logic signed [31:0]     u;
    logic signed [31:0]     v;
    logic signed [31:0]     px;
    logic [31:0]            ax;
    logic [31:0]            ay;
    logic                   sdx;
    logic                   sdy;
    logic                   skip;
    logic [SQ_ROOT_W-1:0]   r;
    logic [DIV_Q_W-1:0]     qt;
  } rvs_side_t;

endpackage

// ===== hw/rtl/rvs_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface rvs_req_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rvs_isqrt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one radicand bit pair resolved per register stage.
// ----------------------------------------------------------------------------
module rvs_isqrt_pipe (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [rvs_pkg::SQ_RAD_W-1:0]   rad_i,
  input  rvs_pkg::rvs_side_t             side_i,
  output logic                           valid_o,
  output logic [rvs_pkg::SQ_ROOT_W-1:0]  root_o,
  output rvs_pkg::rvs_side_t             side_o
);

  localparam int unsigned STEPS = rvs_pkg::SQ_RAD_W / 2;
  localparam int unsigned RW    = rvs_pkg::SQ_ROOT_W + 3;

  logic                            vld_q  [STEPS+1];
  logic [rvs_pkg::SQ_RAD_W-1:0]    rad_q  [STEPS+1];
  logic [RW-1:0]                   rem_q  [STEPS+1];
  logic [rvs_pkg::SQ_ROOT_W-1:0]   root_q [STEPS+1];
  rvs_pkg::rvs_side_t              side_q [STEPS+1];

  assign vld_q[0]  = valid_i;
  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [RW-1:0] remx_d;
    logic [RW-1:0] trial_d;
    logic          take_d;

    always_comb begin
      remx_d  = {rem_q[s][RW-3:0], rad_q[s][rvs_pkg::SQ_RAD_W-1 -: 2]};
      trial_d = {1'b0, root_q[s], 2'b01};
      take_d  = (remx_d >= trial_d);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1]  <= rad_q[s] << 2;
        rem_q[s+1]  <= take_d ? (remx_d - trial_d) : remx_d;
        root_q[s+1] <= {root_q[s][rvs_pkg::SQ_ROOT_W-2:0], take_d};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign root_o  = root_q[STEPS];
  assign side_o  = side_q[STEPS];

endmodule

// ===== hw/rtl/rvs_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// LANES numerators over one shared divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rvs_div_pipe #(
  parameter int unsigned LANES = 1
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [LANES-1:0][rvs_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [rvs_pkg::DIV_DEN_W-1:0]              den_i,
  input  rvs_pkg::rvs_side_t                         side_i,
  output logic                                       valid_o,
  output logic [LANES-1:0][rvs_pkg::DIV_Q_W-1:0]     quo_o,
  output rvs_pkg::rvs_side_t                         side_o
);

  localparam int unsigned STEPS = rvs_pkg::DIV_Q_W;
  localparam int unsigned DW    = rvs_pkg::DIV_DEN_W;
  localparam int unsigned QW    = rvs_pkg::DIV_Q_W;
  localparam int unsigned NW    = rvs_pkg::DIV_NUM_W;

  logic                         vld_q  [STEPS+1];
  logic [LANES-1:0][DW-1:0]     rem_q  [STEPS+1];
  logic [LANES-1:0][QW-1:0]     lo_q   [STEPS+1];
  logic [LANES-1:0][QW-1:0]     quo_q  [STEPS+1];
  logic [DW-1:0]                den_q  [STEPS+1];
  rvs_pkg::rvs_side_t           side_q [STEPS+1];

  // The upper half of each numerator seeds the remainder; the quotient fits only if it is below the divisor.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_q[0][l] = DW'(num_i[l][NW-1:QW]);
      lo_q[0][l]  = num_i[l][QW-1:0];
      quo_q[0][l] = '0;
    end
  end

  assign vld_q[0]  = valid_i;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [LANES-1:0][DW:0]   remx_d;
    logic [LANES-1:0]         take_d;
    logic [LANES-1:0][DW-1:0] rem_d;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        remx_d[l] = {rem_q[s][l], lo_q[s][l][QW-1]};
        take_d[l] = (remx_d[l] >= {1'b0, den_q[s]});
        rem_d[l]  = take_d[l] ? DW'(remx_d[l] - {1'b0, den_q[s]}) : DW'(remx_d[l]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s+1][l] <= rem_d[l];
          lo_q[s+1][l]  <= lo_q[s][l] << 1;
          quo_q[s+1][l] <= {quo_q[s][l][QW-2:0], take_d[l]};
        end
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign quo_o   = quo_q[STEPS];
  assign side_o  = side_q[STEPS];

endmodule

// ===== hw/rtl/rankine_vortex_seed_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rankine vortex seed unit
// Adds a Rankine tangential wind profile to one grid cell per request.
// ----------------------------------------------------------------------------
//
//   Port         Direction  Payload                       Role
//   in_req_i     sink       pos_x pos_y height u v        cell requests
//   out_req_o    source     wind_u_out wind_v_out         adjusted winds
//   cfg_*_i      write      index 0..5, 32-bit data       vortex setup
//
// One request is accepted every cycle while the output is not stalled; each
// passes the 33-stage square root and two 32-stage dividers to its result.
// Reset is asynchronous and active low; it clears all valid bits and loads
// the register defaults. A stall on the output freezes the whole pipeline at
// once, so nothing is dropped or repeated, and ready follows it directly.
//
// Stage plan: offsets and magnitudes, squares, sum, square root, speed
// operand selection, speed product, rounding bias, speed division, projection
// products, rounding bias, projection division, and the saturating sums.
// ----------------------------------------------------------------------------
module rankine_vortex_seed_unit #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rvs_req_if.sink                             in_req_i,
  rvs_req_if.source                           out_req_o,
  input  logic                                cfg_we_i,
  input  logic [rvs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rvs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam logic [30:0] ONE = 31'(1) << COORD_FRAC_BITS;

  // Configuration registers.
  logic               mode_q;
  logic signed [31:0] cx_q;
  logic signed [31:0] cy_q;
  logic [30:0]        core_q;
  logic signed [31:0] ps_q;
  logic signed [31:0] top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cx_q   <= '0;
      cy_q   <= '0;
      core_q <= 31'd256000;
      ps_q   <= '0;
      top_q  <= '0;
    end else if (cfg_we_i) begin
      case (rvs_pkg::rvs_reg_e'(cfg_idx_i))
        rvs_pkg::REG_MODE:        mode_q <= cfg_wdata_i[0];
        rvs_pkg::REG_CENTER_X:    cx_q   <= cfg_wdata_i;
        rvs_pkg::REG_CENTER_Y:    cy_q   <= cfg_wdata_i;
        rvs_pkg::REG_CORE_RADIUS: core_q <= cfg_wdata_i[30:0];
        rvs_pkg::REG_PEAK_SPEED:  ps_q   <= cfg_wdata_i;
        rvs_pkg::REG_SEED_TOP:    top_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The core radius never drops below one metre.
  logic [30:0] core_eff;
  logic [31:0] mps;
  logic        svt;
  assign core_eff = (core_q < ONE) ? ONE : core_q;
  assign mps      = ps_q[31] ? (32'd0 - ps_q) : ps_q;
  assign svt      = ps_q[31];

  // One global advance: every stage moves when the output register can move.
  logic out_vld_q;
  logic en;
  assign en             = !out_vld_q || out_req_o.ready;
  assign in_req_i.ready = en;

  // Stage 1: offsets from the axis and their magnitudes; height test.
  logic signed [32:0] dx, dy;
  logic [32:0]        ndx, ndy;
  rvs_pkg::rvs_side_t s1_d, s1_q;
  logic               s1_vld_q;

  always_comb begin
    dx = {in_req_i.data.pos_x[31], in_req_i.data.pos_x} - {cx_q[31], cx_q};
    dy = {in_req_i.data.pos_y[31], in_req_i.data.pos_y} - {cy_q[31], cy_q};
    ndx = 33'd0 - dx;
    ndy = 33'd0 - dy;
    s1_d      = '0;
    s1_d.u    = in_req_i.data.wind_u_in;
    s1_d.v    = in_req_i.data.wind_v_in;
    s1_d.px   = in_req_i.data.pos_x;
    s1_d.ax   = dx[32] ? ndx[31:0] : dx[31:0];
    s1_d.ay   = dy[32] ? ndy[31:0] : dy[31:0];
    s1_d.sdx  = dx[32];
    s1_d.sdy  = dy[32];
    s1_d.skip = (in_req_i.data.height > top_q);
  end

  // Stage 2: squares.  Stage 3: sum of squares.
  logic [63:0]                   sx_q, sy_q;
  rvs_pkg::rvs_side_t            s2_q, s3_q;
  logic                          s2_vld_q, s3_vld_q;
  logic [rvs_pkg::SQ_RAD_W-1:0]  rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_req_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      sx_q  <= s1_q.ax * s1_q.ax;
      sy_q  <= s1_q.ay * s1_q.ay;
      s2_q  <= s1_q;
      rad_q <= rvs_pkg::SQ_RAD_W'(sx_q) + rvs_pkg::SQ_RAD_W'(sy_q);
      s3_q  <= s2_q;
    end
  end

  logic                           sq_vld;
  logic [rvs_pkg::SQ_ROOT_W-1:0]  sq_root;
  rvs_pkg::rvs_side_t             sq_side;

  rvs_isqrt_pipe u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .rad_i   (rad_q),
    .side_i  (s3_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Speed operands: inside the core the ratio is r/core, outside core/r.
  logic [rvs_pkg::SQ_ROOT_W-1:0] r_sel;
  logic                          in_core;
  rvs_pkg::rvs_side_t            t1_d, t1_q, t2_q, t3_q;
  logic [30:0]                   num_q;
  logic [rvs_pkg::DIV_DEN_W-1:0] den1_q, den2_q, den3_q;
  logic [63:0]                   prod_q, n_q;
  logic                          t1_vld_q, t2_vld_q, t3_vld_q;

  always_comb begin
    if (mode_q) begin
      r_sel = sq_root;
    end else if (sq_side.px > 0) begin
      r_sel = {2'b00, sq_side.px[30:0]};
    end else begin
      r_sel = '0;
    end
    in_core   = (r_sel <= {2'b00, core_eff});
    t1_d      = sq_side;
    t1_d.r    = r_sel;
    t1_d.skip = sq_side.skip || (r_sel == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
      t3_vld_q <= 1'b0;
    end else if (en) begin
      t1_vld_q <= sq_vld;
      t2_vld_q <= t1_vld_q;
      t3_vld_q <= t2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q  <= in_core ? r_sel[30:0] : core_eff;
      den1_q <= in_core ? {2'b00, core_eff} : r_sel;
      t1_q   <= t1_d;
      prod_q <= mps * {1'b0, num_q};
      den2_q <= den1_q;
      t2_q   <= t1_q;
      // Adding half the divisor rounds the magnitude half away from zero.
      n_q    <= prod_q + 64'(den2_q >> 1);
      den3_q <= den2_q;
      t3_q   <= t2_q;
    end
  end

  logic                        d1_vld;
  logic [0:0][31:0]            d1_quo;
  rvs_pkg::rvs_side_t          d1_side;

  rvs_div_pipe #(.LANES(1)) u_div_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t3_vld_q),
    .num_i   (n_q),
    .den_i   (den3_q),
    .side_i  (t3_q),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_side)
  );

  // Projection onto u and v: |vt|*|dy|/r and |vt|*|dx|/r.
  rvs_pkg::rvs_side_t p1_d, p1_q, p2_q;
  logic [63:0]        pu_q, pv_q;
  logic [1:0][63:0]   npr_q;
  logic               p1_vld_q, p2_vld_q;

  always_comb begin
    p1_d    = d1_side;
    p1_d.qt = d1_quo[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= d1_vld;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pu_q     <= d1_quo[0] * d1_side.ay;
      pv_q     <= d1_quo[0] * d1_side.ax;
      p1_q     <= p1_d;
      npr_q[1] <= pu_q + 64'(p1_q.r >> 1);
      npr_q[0] <= pv_q + 64'(p1_q.r >> 1);
      p2_q     <= p1_q;
    end
  end

  logic                d2_vld;
  logic [1:0][31:0]    d2_quo;
  rvs_pkg::rvs_side_t  d2_side;

  rvs_div_pipe #(.LANES(2)) u_div_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p2_vld_q),
    .num_i   (npr_q),
    .den_i   (p2_q.r),
    .side_i  (p2_q),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_side)
  );

  // Final stage: signed increments and saturating sums into the output register.
  logic signed [32:0] du, dv;
  logic [32:0]        qu_x, qv_x, qt_x;
  logic signed [33:0] su, sv;
  rvs_pkg::rvs_out_t  out_d, out_q;

  always_comb begin
    qu_x = {1'b0, d2_quo[1]};
    qv_x = {1'b0, d2_quo[0]};
    qt_x = {1'b0, d2_side.qt};
    if (d2_side.skip) begin
      du = '0;
      dv = '0;
    end else if (mode_q) begin
      // u loses vt*dy/r and v gains vt*dx/r.
      du = (svt ^ d2_side.sdy) ? qu_x : (33'd0 - qu_x);
      dv = (svt ^ d2_side.sdx) ? (33'd0 - qv_x) : qv_x;
    end else begin
      du = '0;
      dv = svt ? (33'd0 - qt_x) : qt_x;
    end
    su = {{2{d2_side.u[31]}}, d2_side.u} + {du[32], du};
    sv = {{2{d2_side.v[31]}}, d2_side.v} + {dv[32], dv};
    if (su[33:31] == 3'b000 || su[33:31] == 3'b111) begin
      out_d.wind_u_out = su[31:0];
    end else begin
      out_d.wind_u_out = su[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (sv[33:31] == 3'b000 || sv[33:31] == 3'b111) begin
      out_d.wind_v_out = sv[31:0];
    end else begin
      out_d.wind_v_out = sv[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_req_o.valid = out_vld_q;
  assign out_req_o.data  = out_q;

  // The clamp keeps every speed division away from a zero divisor.
  a_core_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_eff >= ONE)
    else $error("effective core radius below one metre");

  // A rounded speed never exceeds the configured peak.
  a_speed_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d1_vld && !d1_side.skip) |-> (d1_quo[0] <= mps))
    else $error("tangential speed above peak");

  // Each projected component is bounded by the tangential speed.
  a_proj_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d2_vld && !d2_side.skip && mode_q) |->
      (d2_quo[1] <= d2_side.qt && d2_quo[0] <= d2_side.qt))
    else $error("projected component above tangential speed");

endmodule
